[rtl/core/bpm_pkg.sv]
// busy percent meter package: request payload types, control/status bundles
// and fixed field widths shared by the controller, datapath and top level
// no dependencies

package bpm_pkg;

    // fixed field widths
    localparam int IN_BITS   = 32;
    localparam int PCT_BITS  = 7;
    localparam int STEP_BITS = 3;
    localparam logic [PCT_BITS-1:0] PCT_MAX = 7'd100;

    // input request payload
    typedef struct packed {
        logic                sample_ok;
        logic [IN_BITS-1:0]  total_count;
        logic [IN_BITS-1:0]  idle_count;
    } t_in;

    // output request payload
    typedef struct packed {
        logic [PCT_BITS-1:0] busy_percent;
        logic                measured;
    } t_out;

    // controller to datapath commands
    typedef struct packed {
        logic capture;
        logic delta;
        logic mul;
        logic div_step;
        logic out_load;
    } t_cmd;

    // datapath to controller status
    typedef struct packed {
        logic measure;
        logic div_last;
    } t_sts;

endpackage

[rtl/core/busy_percent_meter_top.sv]
// busy percent meter top level: controller and datapath
// depends on bpm_pkg, bpm_ctrl, bpm_dp
//
// Usage: each input request carries a snapshot of a free-running total
// counter and idle counter plus a usable flag; each one yields exactly one
// output request with the busy share in percent (rounded half up, 0..100)
// and a measured flag. Both channels are valid/ready.
// The first usable snapshot after reset only primes the stored counts.
// Unusable or zero-total snapshots give 0 and leave the stored counts alone.
// Sequence: a measured snapshot passes through delta, scaling, seven
// restoring divide steps (one quotient bit per step) and the output load
// before the next snapshot can be accepted; an unmeasured one goes from
// delta straight to the output load. Output valid is set by the output load.
// Reset (synchronous, active low) clears the stored counts, the primed flag
// and the output valid flag, and returns the sequencer to idle. If the
// receiver stalls, the result waits in the output register; one more
// snapshot is accepted and computed, then the sequencer holds until the
// output register is free.

module busy_percent_meter_top
    import bpm_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in_data,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out_data
);

    t_cmd cmd;
    t_sts sts;

    // sequencer
    bpm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    // arithmetic and stored counts
    bpm_dp #(
        .COUNT_BITS (COUNT_BITS)
    ) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_data  (i_in_data),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out_data (o_out_data)
    );

endmodule

[rtl/core/bpm_dp.sv]
// busy percent meter datapath: snapshot capture, stored counts, wrap-around
// deltas, scaling by 100 and a restoring divider for the rounded percent
// depends on bpm_pkg

module bpm_dp
    import bpm_pkg::*;
#(
    parameter int COUNT_BITS = 32
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_in  i_in_data,
    input  t_cmd i_cmd,
    output t_sts o_sts,
    output t_out o_out_data
);

    localparam int W  = COUNT_BITS;
    localparam int NW = COUNT_BITS + 8;

    logic                 r_ok;
    logic [W-1:0]         r_tot;
    logic [W-1:0]         r_idl;
    logic                 r_primed;
    logic [W-1:0]         r_last_tot;
    logic [W-1:0]         r_last_idl;
    logic [W-1:0]         r_dt;
    logic [W-1:0]         r_busy;
    logic                 r_meas;
    logic [NW-1:0]        r_rem;
    logic [NW-1:0]        r_div;
    logic [PCT_BITS-1:0]  r_quot;
    logic [STEP_BITS-1:0] r_step;
    t_out                 r_out;

    logic [W-1:0]         tot_ext;
    logic [W-1:0]         idl_ext;
    logic [W-1:0]         dt;
    logic [W-1:0]         di;
    logic [W-1:0]         di_clamp;
    logic                 skip;
    logic [NW-1:0]        busy_x;
    logic [NW-1:0]        dt_x;
    logic [NW-1:0]        n_num;
    logic                 ge;
    logic [NW-1:0]        n_rem_sub;
    logic [PCT_BITS-1:0]  pct_sat;

    // fit the 32-bit snapshots to the counter width
    generate
        if (W > IN_BITS) begin : g_wide
            assign tot_ext = {{(W-IN_BITS){1'b0}}, i_in_data.total_count};
            assign idl_ext = {{(W-IN_BITS){1'b0}}, i_in_data.idle_count};
        end else if (W == IN_BITS) begin : g_same
            assign tot_ext = i_in_data.total_count;
            assign idl_ext = i_in_data.idle_count;
        end else begin : g_narrow
            assign tot_ext = i_in_data.total_count[W-1:0];
            assign idl_ext = i_in_data.idle_count[W-1:0];
        end
    endgenerate

    // wrap-around deltas and case decode
    always_comb begin
        dt       = r_tot - r_last_tot;
        di       = r_idl - r_last_idl;
        di_clamp = (di > dt) ? dt : di;
        skip     = !r_ok || (r_tot == '0);
    end

    assign o_sts.measure  = !skip && r_primed && (dt != '0);
    assign o_sts.div_last = (r_step == '0);

    // busy * 100 + total / 2 by shifts and adds
    always_comb begin
        busy_x = {8'd0, r_busy};
        dt_x   = {8'd0, r_dt};
        n_num  = (busy_x << 6) + (busy_x << 5) + (busy_x << 2) + (dt_x >> 1);
    end

    // one restoring divide step
    always_comb begin
        ge        = (r_rem >= r_div);
        n_rem_sub = r_rem - r_div;
        pct_sat   = (r_quot > PCT_MAX) ? PCT_MAX : r_quot;
    end

    // primed flag is control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed <= 1'b0;
        end else if (i_cmd.delta && !skip) begin
            r_primed <= 1'b1;
        end
    end

    // stored counts, reset to zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_tot <= '0;
            r_last_idl <= '0;
        end else if (i_cmd.delta && !skip) begin
            r_last_tot <= r_tot;
            r_last_idl <= r_idl;
        end
    end

    // snapshot capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ok  <= i_in_data.sample_ok;
            r_tot <= tot_ext;
            r_idl <= idl_ext;
        end
    end

    // deltas, scaled numerator and divider iterations
    always_ff @(posedge i_clk) begin
        if (i_cmd.delta) begin
            r_dt   <= dt;
            r_busy <= dt - di_clamp;
            r_meas <= o_sts.measure;
            r_quot <= '0;
        end else if (i_cmd.mul) begin
            r_rem  <= n_num;
            r_div  <= dt_x << 6;
            r_step <= STEP_BITS'(PCT_BITS - 1);
        end else if (i_cmd.div_step) begin
            if (ge) begin
                r_rem <= n_rem_sub;
            end
            r_quot <= {r_quot[PCT_BITS-2:0], ge};
            r_div  <= r_div >> 1;
            r_step <= r_step - 1'b1;
        end
    end

    // output payload register
    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out.busy_percent <= r_meas ? pct_sat : '0;
            r_out.measured     <= r_meas;
        end
    end

    assign o_out_data = r_out;

`ifndef SYNTHESIS
    // remainder stays below twice the shifted divisor, so each quotient bit is exact
    a_rem_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.div_step |-> ({1'b0, r_rem} < {r_div, 1'b0}))
        else $error("divider remainder out of range");
`endif

endmodule

[rtl/core/bpm_ctrl.sv]
// busy percent meter controller: one-hot sequencer over capture, delta,
// scaling, seven divide steps and output load; owns the request handshakes
// depends on bpm_pkg

module bpm_ctrl
    import bpm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [4:0] {
        S_IDLE   = 5'b00001,
        S_DELTA  = 5'b00010,
        S_MUL    = 5'b00100,
        S_DIV    = 5'b01000,
        S_FINISH = 5'b10000
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   out_free;

    assign out_free = !r_out_valid || i_out_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                o_cmd.capture = i_in_valid;
                if (i_in_valid) begin
                    n_state = S_DELTA;
                end
            end
            S_DELTA: begin
                o_cmd.delta = 1'b1;
                n_state     = i_sts.measure ? S_MUL : S_FINISH;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                o_cmd.out_load = out_free;
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // output valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

`ifndef SYNTHESIS
    a_accept_to_delta: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == S_DELTA))
        else $error("accepted request did not start delta step");

    a_div_exit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_FINISH))
        else $error("divider did not finish after last step");

    a_load_sets_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |=> (r_out_valid && r_state == S_IDLE))
        else $error("result load did not raise output valid");
`endif

endmodule

[dv/testbench.sv]
// testbench for busy_percent_meter_top: directed and random snapshot requests
// with a built-in busy percent predictor and an in-order result checker
// depends on bpm_pkg and busy_percent_meter_top

module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import bpm_pkg::*;

    localparam int WATCHDOG_LIMIT   = 2000;
    localparam int MAX_REPORTS      = 10;
    localparam int SETTLE_CYCLES    = 20;
    localparam int RANDOM_PER_PHASE = 380;
    localparam int PAUSE_BURST      = 8;
    localparam int PCT_SCALE        = 100;

    logic i_clk       = 1'b0;
    logic i_rst_n     = 1'b0;
    logic i_in_valid  = 1'b0;
    logic o_in_ready;
    t_in  i_in_data   = '0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    t_out o_out_data;

    // idling knobs, percent of cycles
    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;

    // predicted results waiting for the block
    t_out        pending_pct_q[$];
    t_out        oldest_pct;
    int unsigned fail_count   = 0;
    int unsigned stuck_cycles = 0;

    // predictor state: last usable snapshot
    logic               meter_primed = 1'b0;
    logic [IN_BITS-1:0] prev_total   = '0;
    logic [IN_BITS-1:0] prev_idle    = '0;

    // free-running counters behind the well-formed stimulus
    logic [IN_BITS-1:0] run_total = '0;
    logic [IN_BITS-1:0] run_idle  = '0;

    busy_percent_meter_top u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // busy share of one snapshot, updating the stored counts
    function automatic t_out predict_busy(input t_in req);
        logic [IN_BITS-1:0] d_total;
        logic [IN_BITS-1:0] d_idle;
        logic [63:0]        scaled;
        t_out               res;
        res = '0;
        if (!req.sample_ok || req.total_count == '0) return res;
        if (!meter_primed) begin
            meter_primed = 1'b1;
            prev_total   = req.total_count;
            prev_idle    = req.idle_count;
            return res;
        end
        d_total    = req.total_count - prev_total;
        d_idle     = req.idle_count - prev_idle;
        prev_total = req.total_count;
        prev_idle  = req.idle_count;
        if (d_total == '0) return res;
        if (d_idle > d_total) d_idle = d_total;
        // round half up, then saturate
        scaled = (64'(d_total - d_idle) * 64'(PCT_SCALE) + 64'(d_total >> 1)) / 64'(d_total);
        if (scaled > 64'(PCT_MAX)) scaled = 64'(PCT_MAX);
        res.busy_percent = scaled[PCT_BITS-1:0];
        res.measured     = 1'b1;
        return res;
    endfunction

    function automatic t_in make_snapshot(input logic ok, input logic [IN_BITS-1:0] total,
                                          input logic [IN_BITS-1:0] idle);
        t_in req;
        req.sample_ok   = ok;
        req.total_count = total;
        req.idle_count  = idle;
        return req;
    endfunction

    task automatic note_failure(input string what);
        fail_count++;
        if (fail_count <= MAX_REPORTS) $display("%0t: %s", $time, what);
    endtask

    // one input request, with random gaps ahead of it
    task automatic send_snapshot(input t_in req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        pending_pct_q.push_back(predict_busy(req));
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        while (pending_pct_q.size() != 0) @(posedge i_clk);
    endtask

    // extremes, every special case, rounding and wrap-around
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // unusable and zero-total snapshots before priming
        send_snapshot(make_snapshot(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_snapshot(make_snapshot(1'b1, 32'h0000_0000, 32'h0000_3039));
        send_snapshot(make_snapshot(1'b0, 32'h0000_0000, 32'h0000_0000));
        // first usable snapshot primes
        send_snapshot(make_snapshot(1'b1, 32'd1000, 32'd100));
        send_snapshot(make_snapshot(1'b1, 32'd2000, 32'd600));
        // zero total delta, counts still stored
        send_snapshot(make_snapshot(1'b1, 32'd2000, 32'd700));
        // no idle at all
        send_snapshot(make_snapshot(1'b1, 32'd3000, 32'd700));
        // idle delta above total delta
        send_snapshot(make_snapshot(1'b1, 32'd3200, 32'd5000));
        // unusable and zero total after priming leave state alone
        send_snapshot(make_snapshot(1'b0, 32'd9999, 32'd9999));
        send_snapshot(make_snapshot(1'b1, 32'd0, 32'd0));
        // exact half rounds up, just under one percent rounds to one
        send_snapshot(make_snapshot(1'b1, 32'd3400, 32'd5199));
        send_snapshot(make_snapshot(1'b1, 32'd3601, 32'd5398));
        send_snapshot(make_snapshot(1'b1, 32'd3801, 32'd5597));
        send_snapshot(make_snapshot(1'b1, 32'd4001, 32'd5796));
        // 99.5 percent rounds to 100
        send_snapshot(make_snapshot(1'b1, 32'd4201, 32'd5797));
        // large counts and total wrap
        send_snapshot(make_snapshot(1'b1, 32'hFFFF_FFF0, 32'hFFFF_FF00));
        send_snapshot(make_snapshot(1'b1, 32'h0000_0010, 32'h0000_0005));
        // largest total delta, all busy then all idle
        send_snapshot(make_snapshot(1'b1, 32'h0000_000F, 32'h0000_0005));
        send_snapshot(make_snapshot(1'b1, 32'h0000_000E, 32'h0000_0004));
        // all-ones counts
        send_snapshot(make_snapshot(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send_snapshot(make_snapshot(1'b1, 32'hFFFF_FFFF, 32'h0000_0000));
        send_snapshot(make_snapshot(1'b1, 32'h8000_0000, 32'h5555_5555));
        send_snapshot(make_snapshot(1'b1, 32'h0000_0001, 32'hAAAA_AAAA));
        run_total = 32'h0000_0001;
        run_idle  = 32'hAAAA_AAAA;
    endtask

    // sender holds off until every result is back, then resumes
    task automatic test_pause_until_drained();
        send_idle_pct  = 34;
        recv_stall_pct = 34;
        for (int i = 0; i < 2 * PAUSE_BURST; i++) begin
            run_total = run_total + $urandom_range(5000, 1);
            run_idle  = run_idle + $urandom_range(1000, 0);
            send_snapshot(make_snapshot(1'b1, run_total, run_idle));
            if (i == PAUSE_BURST - 1) wait_drained();
        end
    endtask

    // mostly well-formed counter sequences, some noise and broken snapshots
    task automatic test_random(input int unsigned count, input int unsigned idle_pct,
                               input int unsigned stall_pct);
        logic [IN_BITS-1:0] d_total;
        logic [IN_BITS-1:0] d_idle;
        int unsigned        kind;
        t_in                req;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int unsigned n = 0; n < count; n++) begin
            case ($urandom_range(3))
                0: d_total = $urandom_range(100, 1);
                1: d_total = $urandom_range(1000000, 1);
                2: d_total = $urandom;
                default: d_total = 32'hFFFF_FFFF - $urandom_range(3, 0);
            endcase
            case ($urandom_range(3))
                0: d_idle = '0;
                1: d_idle = d_total;
                default: d_idle = $urandom_range(d_total, 0);
            endcase
            kind = $urandom_range(99);
            if (kind < 70) begin
                run_total = run_total + d_total;
                run_idle  = run_idle + d_idle;
                req = make_snapshot(1'b1, run_total, run_idle);
            end else if (kind < 78) begin
                run_idle = run_idle + d_idle;
                req = make_snapshot(1'b1, run_total, run_idle);
            end else if (kind < 85) begin
                run_total = run_total + d_total;
                run_idle  = run_idle + d_total + $urandom_range(1000, 1);
                req = make_snapshot(1'b1, run_total, run_idle);
            end else if (kind < 92) begin
                req = make_snapshot(1'b0, $urandom, $urandom);
            end else if (kind < 96) begin
                req = make_snapshot(1'b1, '0, $urandom);
            end else begin
                req = make_snapshot(1'($urandom_range(1)), $urandom, $urandom);
            end
            send_snapshot(req);
        end
    endtask

    // receiver back-pressure
    always @(posedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // compare each result request with the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_pct_q.size() == 0) begin
                note_failure($sformatf("unexpected result busy_percent %0d measured %0b",
                                       o_out_data.busy_percent, o_out_data.measured));
            end else begin
                oldest_pct = pending_pct_q.pop_front();
                if (o_out_data.busy_percent !== oldest_pct.busy_percent ||
                    o_out_data.measured !== oldest_pct.measured) begin
                    note_failure($sformatf({"result mismatch: busy_percent exp %0d got %0d, ",
                                            "measured exp %0b got %0b"},
                                           oldest_pct.busy_percent, o_out_data.busy_percent,
                                           oldest_pct.measured, o_out_data.measured));
                end
            end
        end
    end

    // watchdog on cycles with no accepted request on either side
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("FAIL busy_percent_meter_top");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_pause_until_drained();
        test_random(RANDOM_PER_PHASE, 0, 0);
        test_random(RANDOM_PER_PHASE, 71, 0);
        test_random(RANDOM_PER_PHASE, 0, 71);
        test_random(RANDOM_PER_PHASE, 34, 34);

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && pending_pct_q.size() == 0) begin
            $display("PASS busy_percent_meter_top");
        end else begin
            $display("FAIL busy_percent_meter_top");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/core/bpm_pkg.sv
rtl/core/bpm_dp.sv
rtl/core/bpm_ctrl.sv
rtl/core/busy_percent_meter_top.sv
dv/testbench.sv
